### rtl/core/olf_pkg.sv
// olf_pkg: shared types and widths for the occurrence limit filter.
// No dependencies; used by olf_front, olf_table and occurrence_limit_filter_core.
package olf_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd1;

  // One queued input transaction.
  typedef struct packed {
    logic                      end_of_sequence;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic                      last_out;
    logic                      table_overflow;
    logic                      keep;
    logic signed [VALUE_W-1:0] value_out;
  } result_t;

endpackage

### rtl/core/olf_front.sv
// olf_front: input side of the filter; accepts stream transactions into a short queue.
// Depends on olf_pkg.
module olf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [olf_pkg::VALUE_W-1:0] in_tdata,   // [31:0] value
  input  logic                        in_tlast,   // end_of_sequence
  output logic                        q_valid,
  output olf_pkg::item_t              q_item,
  input  logic                        q_ready
);

  localparam int unsigned PTR_W = $clog2(olf_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(olf_pkg::QUEUE_DEPTH + 1);

  olf_pkg::item_t     slot_r [olf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;

  assign in_tready = (cnt_r != CNT_W'(olf_pkg::QUEUE_DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_item    = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(olf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(olf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{end_of_sequence: in_tlast, value: in_tdata};
    end
  end

endmodule

### rtl/core/olf_table.sv
// olf_table: back end; content-addressed table of values with saturating counts
// and the registered result stage. Depends on olf_pkg.
module olf_table #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [olf_pkg::COUNT_W-1:0] limit,
  input  logic                        q_valid,
  input  olf_pkg::item_t              q_item,
  output logic                        q_ready,
  output logic                        res_valid,
  output olf_pkg::result_t            res,
  input  logic                        res_ready
);

  localparam int unsigned USED_W = $clog2(TABLE_ENTRIES + 1);

  // Per-entry cells: key and count, no reset (validity comes from the fill count).
  logic [olf_pkg::VALUE_W-1:0] key_r   [TABLE_ENTRIES];
  logic [olf_pkg::COUNT_W-1:0] count_r [TABLE_ENTRIES];
  logic [USED_W-1:0]           used_r, used_nxt;

  logic [TABLE_ENTRIES-1:0] hit_vec, below_vec, slot_vec;
  logic                     hit, keep_hit, full, alloc, fire;
  logic                     limit_zero;
  olf_pkg::result_t         res_r, res_nxt;
  logic                     res_valid_r;

  assign q_ready    = !res_valid_r || res_ready;
  assign fire       = q_valid && q_ready;
  assign limit_zero = (limit == '0);

  // Entries fill in index order, so entry i is live exactly when i < used_r.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    assign hit_vec[i]   = (USED_W'(i) < used_r) && (key_r[i] == q_item.value);
    assign below_vec[i] = (count_r[i] < limit);
    assign slot_vec[i]  = (USED_W'(i) == used_r);

    always_ff @(posedge clk) begin
      if (fire) begin
        if (hit_vec[i] && below_vec[i]) begin
          count_r[i] <= count_r[i] + 1'b1;
        end else if (alloc && slot_vec[i]) begin
          key_r[i]   <= q_item.value;
          count_r[i] <= limit_zero ? '0 : olf_pkg::COUNT_W'(1);
        end
      end
    end
  end

  assign hit      = |hit_vec;
  assign keep_hit = |(hit_vec & below_vec);
  assign full     = (used_r == USED_W'(TABLE_ENTRIES));
  assign alloc    = !hit && !full;

  always_comb begin
    res_nxt.value_out      = q_item.value;
    res_nxt.last_out       = q_item.end_of_sequence;
    res_nxt.table_overflow = !hit && full;
    if (hit) begin
      res_nxt.keep = keep_hit;
    end else if (full) begin
      res_nxt.keep = 1'b1;
    end else begin
      res_nxt.keep = !limit_zero;
    end

    used_nxt = used_r;
    if (q_item.end_of_sequence) begin
      used_nxt = '0;
    end else if (alloc) begin
      used_nxt = used_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        used_r <= used_nxt;
      end
      if (q_ready) begin
        res_valid_r <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

### rtl/core/occurrence_limit_filter_core.sv
// occurrence_limit_filter_core: top level of the per-value occurrence limit filter.
// Depends on olf_pkg, olf_front and olf_table.
//
// The block takes one signed 32-bit value per transaction and returns one result per
// transaction, in order: the value unchanged, keep (set while fewer than max_occurrences
// earlier values of the current sequence matched it), table_overflow (a new value found
// all TABLE_ENTRIES entries in use; such a value is kept) and last_out. A transaction
// with in_tlast set is judged first, then the table is emptied. It sustains one
// transaction per clock while out_tready stays high. A result passes through the queue
// entry and then the result register before it is valid. The table stage compares the
// value with every entry and updates the matching count or allocates the next free
// entry as it accepts the transaction, which is what allows one transaction per clock.
// A two-entry queue sits between input and table, and a registered result stage
// follows, so either side may stall on its own. max_occurrences resets to 1 and is
// written through cfg_wr_en/cfg_wr_data; the user must do so only while no transaction
// is in flight, the block does not enforce it. No clearing pass is needed after reset.
module occurrence_limit_filter_core #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: max_occurrences
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // [15:0] max_occurrences
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [31:0] value
  input  logic        in_tlast,      // end_of_sequence
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [31:0] value_out
  output logic [1:0]  out_tuser,     // [0] keep, [1] table_overflow
  output logic        out_tlast      // last_out
);

  logic [olf_pkg::COUNT_W-1:0] limit_r;
  logic                        q_valid, q_ready;
  olf_pkg::item_t              q_item;
  olf_pkg::result_t            res;

  // Limit register; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= olf_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  olf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready)
  );

  olf_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tdata = res.value_out;
  assign out_tuser = {res.table_overflow, res.keep};
  assign out_tlast = res.last_out;

endmodule

### rtl/core/olf_checker.sv
// olf_checker: port-level assertions for occurrence_limit_filter_core, bound to the top.
// Depends only on the top level's ports.
module olf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // Transactions accepted but not yet delivered.
  logic [2:0] inflight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 3'(in_tvalid && in_tready) - 3'(out_tvalid && out_tready);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_ovf_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("overflowed value not kept");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> inflight_r != 3'd0)
    else $error("result without an accepted input");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd3)
    else $error("more transactions in flight than storage holds");

endmodule

bind occurrence_limit_filter_core olf_checker u_olf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
